// File: hdl/mag_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mag_pkg
// Shared types, constants and helpers of the multicolor ant grid step block.
// ----------------------------------------------------------------------------
package mag_pkg;

    // Grid and rule sizing
    localparam int GRID_SIDE  = 256;
    localparam int NUM_SHADES = 16;
    localparam int CELL_DEPTH = GRID_SIDE * GRID_SIDE;
    localparam int CELL_AW    = $clog2(CELL_DEPTH);
    localparam int DIM_LIM    = (GRID_SIDE < 256) ? GRID_SIDE : 256;

    // Field widths
    localparam int KIND_W  = 3;
    localparam int COORD_W = 8;
    localparam int DIM_W   = 9;
    localparam int SHADE_W = 4;
    localparam int TURN_W  = 2;
    localparam int HEAD_W  = 2;
    localparam int STAT_W  = 2;
    localparam int RULES   = 1 << SHADE_W;

    // Configuration register file
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam logic REG_GRID_WIDTH  = 1'b0;
    localparam logic REG_GRID_HEIGHT = 1'b1;

    // Item kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_STEP  = 3'd0,
        KIND_LOAD  = 3'd1,
        KIND_WRITE = 3'd2,
        KIND_PLACE = 3'd3,
        KIND_READ  = 3'd4
    } kind_t;

    // Result status codes
    typedef enum logic [STAT_W-1:0] {
        STAT_OK     = 2'd0,
        STAT_EDGE   = 2'd1,
        STAT_NORULE = 2'd2
    } status_t;

    // Rule turn codes
    localparam logic [TURN_W-1:0] TURN_OFF = 2'd3;

    // Headings
    typedef enum logic [HEAD_W-1:0] {
        HEAD_N    = 2'd0,
        HEAD_E    = 2'd1,
        HEAD_S    = 2'd2,
        HEAD_WEST = 2'd3
    } heading_t;

    // Control sequencer states
    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC
    } state_t;

    // Effective grid size in use
    typedef struct packed {
        logic [DIM_W-1:0] eff_w;
        logic [DIM_W-1:0] eff_h;
    } dims_t;

    // Cell memory request
    typedef struct packed {
        logic               we;
        logic [CELL_AW-1:0] addr;
        logic [SHADE_W-1:0] wdata;
    } mem_req_t;

    // Linear cell address of a row and column
    function automatic logic [CELL_AW-1:0] cell_addr(
        input logic [COORD_W-1:0] r,
        input logic [COORD_W-1:0] c
    );
        logic [31:0] idx;
        idx = 32'(r) * 32'(GRID_SIDE) + 32'(c);
        return idx[CELL_AW-1:0];
    endfunction

endpackage
`default_nettype wire

// File: hdl/mag_cell_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mag_cell_ram
// Single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module mag_cell_ram #(
    parameter int DEPTH = 65536,
    parameter int WIDTH = 4
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and read at one address per cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// File: hdl/mag_cfg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mag_cfg
// APB register file for the grid size; derives the clamped size in use.
// ----------------------------------------------------------------------------
module mag_cfg (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [mag_pkg::APB_AW-1:0]     paddr,
    input  wire logic [mag_pkg::APB_DW-1:0]     pwdata,
    output logic      [mag_pkg::APB_DW-1:0]     prdata,
    output logic                                pready,
    output mag_pkg::dims_t                      dims
);
    import mag_pkg::*;

    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] width_next;
    logic [DIM_W-1:0] height_reg;
    logic [DIM_W-1:0] height_next;
    logic             wr_en;
    logic             reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[2];

    // Register write decode
    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        if (wr_en)
        begin
            unique case (reg_sel)
                REG_GRID_WIDTH:  width_next  = pwdata[DIM_W-1:0];
                REG_GRID_HEIGHT: height_next = pwdata[DIM_W-1:0];
                default:         width_next  = width_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DIM_W'(256);
            height_reg <= DIM_W'(256);
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    // Read back
    always_comb
    begin
        unique case (reg_sel)
            REG_GRID_WIDTH:  prdata = APB_DW'(width_reg);
            REG_GRID_HEIGHT: prdata = APB_DW'(height_reg);
            default:         prdata = '0;
        endcase
    end

    // Clamp to 1..DIM_LIM
    always_comb
    begin
        if (width_reg == '0)
            dims.eff_w = DIM_W'(1);
        else if (width_reg > DIM_W'(DIM_LIM))
            dims.eff_w = DIM_W'(DIM_LIM);
        else
            dims.eff_w = width_reg;

        if (height_reg == '0)
            dims.eff_h = DIM_W'(1);
        else if (height_reg > DIM_W'(DIM_LIM))
            dims.eff_h = DIM_W'(DIM_LIM);
        else
            dims.eff_h = height_reg;
    end

endmodule
`default_nettype wire

// File: hdl/mag_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mag_ctrl
// Item sequencer: rule file, ant state, cell memory access and result word.
// ----------------------------------------------------------------------------
module mag_ctrl (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // input words
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [mag_pkg::KIND_W-1:0]    kind,
    input  wire logic [mag_pkg::COORD_W-1:0]   row,
    input  wire logic [mag_pkg::COORD_W-1:0]   col,
    input  wire logic [mag_pkg::SHADE_W-1:0]   shade,
    input  wire logic [mag_pkg::SHADE_W-1:0]   new_shade,
    input  wire logic [mag_pkg::TURN_W-1:0]    turn,
    input  wire logic [mag_pkg::HEAD_W-1:0]    heading,
    // result words
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic      [mag_pkg::STAT_W-1:0]    status,
    output logic      [mag_pkg::COORD_W-1:0]   ant_row_out,
    output logic      [mag_pkg::COORD_W-1:0]   ant_col_out,
    output logic      [mag_pkg::HEAD_W-1:0]    ant_heading_out,
    output logic      [mag_pkg::SHADE_W-1:0]   read_shade,
    // grid size and cell memory
    input  wire mag_pkg::dims_t                dims,
    output mag_pkg::mem_req_t                  mem_req,
    input  wire logic [mag_pkg::SHADE_W-1:0]   mem_rdata
);
    import mag_pkg::*;

    localparam logic [CELL_AW-1:0] CLR_LAST = CELL_AW'(CELL_DEPTH - 1);

    state_t             state_reg;
    state_t             state_next;
    logic [CELL_AW-1:0] clr_cnt_reg;
    logic [CELL_AW-1:0] clr_cnt_next;
    logic               is_read_reg;
    logic               is_read_next;

    // rule file
    logic               rule_vld_reg  [RULES];
    logic [TURN_W-1:0]  rule_turn_reg [RULES];
    logic [SHADE_W-1:0] rule_repl_reg [RULES];
    logic               rule_we;

    // ant
    logic [COORD_W-1:0] ant_row_reg;
    logic [COORD_W-1:0] ant_row_next;
    logic [COORD_W-1:0] ant_col_reg;
    logic [COORD_W-1:0] ant_col_next;
    logic [HEAD_W-1:0]  ant_head_reg;
    logic [HEAD_W-1:0]  ant_head_next;

    // result register
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [STAT_W-1:0]  status_reg;
    logic [STAT_W-1:0]  status_next;
    logic [SHADE_W-1:0] rd_reg;
    logic [SHADE_W-1:0] rd_next;
    logic [COORD_W-1:0] out_row_reg;
    logic [COORD_W-1:0] out_col_reg;
    logic [HEAD_W-1:0]  out_head_reg;
    logic               out_load;

    // helpers
    logic               in_fire;
    logic               out_free;
    logic               in_inside;
    logic               needs_read;
    logic               shade_ok;
    logic               new_shade_ok;
    logic [CELL_AW-1:0] ant_addr;
    logic [CELL_AW-1:0] in_addr;
    logic [HEAD_W-1:0]  step_head;
    logic [DIM_W-1:0]   nr9;
    logic [DIM_W-1:0]   nc9;
    logic               step_ok;

    assign out_free     = !out_valid_reg || !out_stall;
    assign in_fire      = in_valid && !in_stall;
    assign in_inside    = ({1'b0, row} < dims.eff_h) && ({1'b0, col} < dims.eff_w);
    assign needs_read   = (kind == KIND_STEP) || ((kind == KIND_READ) && in_inside);
    assign shade_ok     = 32'(shade) < NUM_SHADES;
    assign new_shade_ok = 32'(new_shade) < NUM_SHADES;
    assign ant_addr     = cell_addr(ant_row_reg, ant_col_reg);
    assign in_addr      = cell_addr(row, col);

    // Step datapath: rule lookup, turn, target cell
    assign step_ok   = (32'(mem_rdata) < NUM_SHADES) && rule_vld_reg[mem_rdata];
    assign step_head = ant_head_reg + HEAD_W'(3) + rule_turn_reg[mem_rdata];
    always_comb
    begin
        nr9 = {1'b0, ant_row_reg};
        nc9 = {1'b0, ant_col_reg};
        unique case (step_head)
            HEAD_N:    nr9 = {1'b0, ant_row_reg} - DIM_W'(1);
            HEAD_E:    nc9 = {1'b0, ant_col_reg} + DIM_W'(1);
            HEAD_S:    nr9 = {1'b0, ant_row_reg} + DIM_W'(1);
            HEAD_WEST: nc9 = {1'b0, ant_col_reg} - DIM_W'(1);
            default:   nr9 = {1'b0, ant_row_reg};
        endcase
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR: if (clr_cnt_reg == CLR_LAST) state_next = S_IDLE;
            S_IDLE:  if (in_fire && needs_read) state_next = S_EXEC;
            S_EXEC:  state_next = S_IDLE;
            default: state_next = S_CLEAR;
        endcase
    end

    // Outputs and datapath control
    always_comb
    begin
        in_stall      = 1'b1;
        mem_req.we    = 1'b0;
        mem_req.addr  = ant_addr;
        mem_req.wdata = '0;
        clr_cnt_next  = clr_cnt_reg;
        is_read_next  = is_read_reg;
        rule_we       = 1'b0;
        ant_row_next  = ant_row_reg;
        ant_col_next  = ant_col_reg;
        ant_head_next = ant_head_reg;
        status_next   = STAT_OK;
        rd_next       = '0;
        out_load      = 1'b0;

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_req.we   = 1'b1;
                mem_req.addr = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + CELL_AW'(1);
            end
            S_IDLE:
            begin
                in_stall = !out_free;
                if (in_fire)
                begin
                    is_read_next = (kind == KIND_READ);
                    unique case (kind)
                        KIND_STEP:
                        begin
                            mem_req.addr = ant_addr;
                        end
                        KIND_LOAD:
                        begin
                            out_load = 1'b1;
                            if (!shade_ok || !new_shade_ok)
                                status_next = STAT_NORULE;
                            else
                                rule_we = 1'b1;
                        end
                        KIND_WRITE:
                        begin
                            out_load = 1'b1;
                            if (!shade_ok)
                                status_next = STAT_NORULE;
                            else if (!in_inside)
                                status_next = STAT_EDGE;
                            else
                            begin
                                mem_req.we    = 1'b1;
                                mem_req.addr  = in_addr;
                                mem_req.wdata = shade;
                            end
                        end
                        KIND_PLACE:
                        begin
                            out_load = 1'b1;
                            if (!in_inside)
                                status_next = STAT_EDGE;
                            else
                            begin
                                ant_row_next  = row;
                                ant_col_next  = col;
                                ant_head_next = heading;
                            end
                        end
                        KIND_READ:
                        begin
                            mem_req.addr = in_addr;
                            if (!in_inside)
                            begin
                                out_load    = 1'b1;
                                status_next = STAT_EDGE;
                            end
                        end
                        default:
                        begin
                            out_load = 1'b1;
                        end
                    endcase
                end
            end
            S_EXEC:
            begin
                out_load = 1'b1;
                if (is_read_reg)
                    rd_next = mem_rdata;
                else if (!step_ok)
                    status_next = STAT_NORULE;
                else
                begin
                    ant_head_next = step_head;
                    mem_req.we    = 1'b1;
                    mem_req.addr  = ant_addr;
                    mem_req.wdata = rule_repl_reg[mem_rdata];
                    if ((nr9 < dims.eff_h) && (nc9 < dims.eff_w))
                    begin
                        ant_row_next = nr9[COORD_W-1:0];
                        ant_col_next = nc9[COORD_W-1:0];
                    end
                    else
                        status_next = STAT_EDGE;
                end
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    // Result handshake
    always_comb
    begin
        if (out_load)
            out_valid_next = 1'b1;
        else if (out_stall)
            out_valid_next = out_valid_reg;
        else
            out_valid_next = 1'b0;
    end

    // Control and ant registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            is_read_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            ant_row_reg   <= '0;
            ant_col_reg   <= '0;
            ant_head_reg  <= HEAD_N;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            is_read_reg   <= is_read_next;
            out_valid_reg <= out_valid_next;
            ant_row_reg   <= ant_row_next;
            ant_col_reg   <= ant_col_next;
            ant_head_reg  <= ant_head_next;
        end
    end

    // Rule file; a turn of three clears the rule
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < RULES; i++)
            begin
                rule_vld_reg[i] <= 1'b0;
            end
        end
        else if (rule_we)
        begin
            rule_vld_reg[shade] <= (turn != TURN_OFF);
        end
    end

    always_ff @(posedge clk)
    begin
        if (rule_we)
        begin
            rule_turn_reg[shade] <= (turn != TURN_OFF) ? turn : '0;
            rule_repl_reg[shade] <= new_shade;
        end
    end

    // Result word payload
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            status_reg   <= status_next;
            rd_reg       <= rd_next;
            out_row_reg  <= ant_row_next;
            out_col_reg  <= ant_col_next;
            out_head_reg <= ant_head_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign status          = status_reg;
    assign read_shade      = rd_reg;
    assign ant_row_out     = out_row_reg;
    assign ant_col_out     = out_col_reg;
    assign ant_heading_out = out_head_reg;

endmodule
`default_nettype wire

// File: hdl/multicolor_ant_grid_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// multicolor_ant_grid_step
// Multicolor turmite on a grid of 4-bit shades, one result word per item.
// ----------------------------------------------------------------------------
// After reset the block clears the cell memory one cell per cycle, with
// in_stall held high; the APB registers can be written during that time.
// After that, load rule, write cell, place ant, out-of-grid read and unused
// kinds complete in S_IDLE, where they are taken; a step or an in-grid cell
// read goes on to S_EXEC, which uses the registered read data of the
// single-port cell memory, and a step then writes the cell back there. One
// item is in flight at a time, and a new item is taken in the same cycle
// that the previous result word leaves the output register.
// ----------------------------------------------------------------------------
module multicolor_ant_grid_step (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // configuration
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [mag_pkg::APB_AW-1:0]    paddr,
    input  wire logic [mag_pkg::APB_DW-1:0]    pwdata,
    output logic      [mag_pkg::APB_DW-1:0]    prdata,
    output logic                               pready,
    // input words
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [mag_pkg::KIND_W-1:0]    kind,
    input  wire logic [mag_pkg::COORD_W-1:0]   row,
    input  wire logic [mag_pkg::COORD_W-1:0]   col,
    input  wire logic [mag_pkg::SHADE_W-1:0]   shade,
    input  wire logic [mag_pkg::SHADE_W-1:0]   new_shade,
    input  wire logic [mag_pkg::TURN_W-1:0]    turn,
    input  wire logic [mag_pkg::HEAD_W-1:0]    heading,
    // result words
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic      [mag_pkg::STAT_W-1:0]    status,
    output logic      [mag_pkg::COORD_W-1:0]   ant_row_out,
    output logic      [mag_pkg::COORD_W-1:0]   ant_col_out,
    output logic      [mag_pkg::HEAD_W-1:0]    ant_heading_out,
    output logic      [mag_pkg::SHADE_W-1:0]   read_shade
);
    import mag_pkg::*;

    dims_t              dims;
    mem_req_t           mem_req;
    logic [SHADE_W-1:0] mem_rdata;

    // Grid size registers
    mag_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .dims    (dims)
    );

    // Cell memory
    mag_cell_ram #(
        .DEPTH (CELL_DEPTH),
        .WIDTH (SHADE_W)
    ) u_cell_ram (
        .clk   (clk),
        .we    (mem_req.we),
        .addr  (mem_req.addr),
        .wdata (mem_req.wdata),
        .rdata (mem_rdata)
    );

    // Sequencer
    mag_ctrl u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .kind            (kind),
        .row             (row),
        .col             (col),
        .shade           (shade),
        .new_shade       (new_shade),
        .turn            (turn),
        .heading         (heading),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .status          (status),
        .ant_row_out     (ant_row_out),
        .ant_col_out     (ant_col_out),
        .ant_heading_out (ant_heading_out),
        .read_shade      (read_shade),
        .dims            (dims),
        .mem_req         (mem_req),
        .mem_rdata       (mem_rdata)
    );

endmodule
`default_nettype wire

// File: dv/testbench.sv
`default_nettype none
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the multicolor ant grid step block.
// ----------------------------------------------------------------------------
// Words go in and out over valid/stall channels with random gaps and stalls.
// A behavioral model of the grid, the rules and the ant runs on every
// accepted input word and queues the result word it owes. Each result word
// that leaves the block is checked field by field against the oldest entry.
// A short directed table comes first. Random phases follow, each under its
// own grid size, written over APB while nothing is in flight.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import mag_pkg::*;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic [SHADE_W-1:0] shade;
        logic [SHADE_W-1:0] new_shade;
        logic [TURN_W-1:0]  turn;
        logic [HEAD_W-1:0]  heading;
    } in_word_t;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [COORD_W-1:0] arow;
        logic [COORD_W-1:0] acol;
        logic [HEAD_W-1:0]  ahead;
        logic [SHADE_W-1:0] rd;
    } out_word_t;

    typedef struct packed {
        in_word_t  w;
        logic      chk;
        out_word_t res;
    } dir_row_t;

    // Turn codes of a rule, and kind codes with no operation
    localparam logic [TURN_W-1:0] TURN_LEFT  = 2'd0;
    localparam logic [TURN_W-1:0] TURN_NONE  = 2'd1;
    localparam logic [TURN_W-1:0] TURN_RIGHT = 2'd2;
    localparam logic [KIND_W-1:0] KIND_SPARE0 = 3'd5;
    localparam logic [KIND_W-1:0] KIND_SPARE1 = 3'd6;
    localparam logic [KIND_W-1:0] KIND_SPARE2 = 3'd7;

    localparam logic [APB_AW-1:0] ADDR_WIDTH  = {REG_GRID_WIDTH, 2'b00};
    localparam logic [APB_AW-1:0] ADDR_HEIGHT = {REG_GRID_HEIGHT, 2'b00};

    localparam logic      CHK    = 1'b1;
    localparam logic      PRED   = 1'b0;
    localparam out_word_t NO_RES = '0;
    localparam int        N_DIR    = 25;
    localparam int        N_PHASES = 10;

    logic                 clk;
    logic                 rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [APB_AW-1:0]    paddr;
    logic [APB_DW-1:0]    pwdata;
    logic [APB_DW-1:0]    prdata;
    logic                 pready;
    logic                 in_valid;
    logic                 in_stall;
    logic [KIND_W-1:0]    kind;
    logic [COORD_W-1:0]   row;
    logic [COORD_W-1:0]   col;
    logic [SHADE_W-1:0]   shade;
    logic [SHADE_W-1:0]   new_shade;
    logic [TURN_W-1:0]    turn;
    logic [HEAD_W-1:0]    heading;
    logic                 out_valid;
    logic                 out_stall;
    logic [STAT_W-1:0]    status;
    logic [COORD_W-1:0]   ant_row_out;
    logic [COORD_W-1:0]   ant_col_out;
    logic [HEAD_W-1:0]    ant_heading_out;
    logic [SHADE_W-1:0]   read_shade;

    // typed-in expectation riding along with the input word
    logic                 drv_chk;
    out_word_t            drv_res;

    // model state
    logic [SHADE_W-1:0]   shade_grid [CELL_DEPTH];
    logic                 rule_on    [RULES];
    logic [TURN_W-1:0]    rule_turn  [RULES];
    logic [SHADE_W-1:0]   rule_repl  [RULES];
    logic [COORD_W-1:0]   ant_r;
    logic [COORD_W-1:0]   ant_c;
    logic [HEAD_W-1:0]    ant_h;
    logic [DIM_W-1:0]     grid_w;
    logic [DIM_W-1:0]     grid_h;

    out_word_t            owed_results [$];
    int                   n_err;
    int                   n_in;
    int                   n_out;
    bit                   no_idle;

    dir_row_t             dir_tab [N_DIR];

    multicolor_ant_grid_step u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .kind            (kind),
        .row             (row),
        .col             (col),
        .shade           (shade),
        .new_shade       (new_shade),
        .turn            (turn),
        .heading         (heading),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .status          (status),
        .ant_row_out     (ant_row_out),
        .ant_col_out     (ant_col_out),
        .ant_heading_out (ant_heading_out),
        .read_shade      (read_shade)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Model of the block
    // ------------------------------------------------------------------

    // size in use: zero counts as one, large values clamp
    function automatic int clamp_dim(logic [DIM_W-1:0] v);
        if (v == '0)
            return 1;
        return (int'(v) > DIM_LIM) ? DIM_LIM : int'(v);
    endfunction

    function automatic bit on_grid(int r, int c);
        return r >= 0 && c >= 0 && r < clamp_dim(grid_h) && c < clamp_dim(grid_w);
    endfunction

    function automatic void clear_model();
        for (int i = 0; i < CELL_DEPTH; i++)
            shade_grid[i] = '0;
        for (int i = 0; i < RULES; i++)
        begin
            rule_on[i]   = 1'b0;
            rule_turn[i] = '0;
            rule_repl[i] = '0;
        end
        ant_r  = '0;
        ant_c  = '0;
        ant_h  = HEAD_N;
        grid_w = 9'd256;
        grid_h = 9'd256;
    endfunction

    // applies one input word to the model and returns the result word
    function automatic out_word_t apply_word(in_word_t w);
        out_word_t          r;
        int                 idx;
        int                 nr;
        int                 nc;
        logic [SHADE_W-1:0] sh;
        logic [HEAD_W-1:0]  h;
        r = NO_RES;
        r.status = STAT_OK;
        case (w.kind)
            KIND_STEP:
            begin
                idx = int'(ant_r) * GRID_SIDE + int'(ant_c);
                sh  = shade_grid[idx];
                if (!rule_on[sh])
                    r.status = STAT_NORULE;
                else
                begin
                    h = ant_h + 2'd3 + rule_turn[sh];
                    ant_h = h;
                    shade_grid[idx] = rule_repl[sh];
                    nr = int'(ant_r);
                    nc = int'(ant_c);
                    case (h)
                        HEAD_N:  nr = nr - 1;
                        HEAD_E:  nc = nc + 1;
                        HEAD_S:  nr = nr + 1;
                        default: nc = nc - 1;
                    endcase
                    if (!on_grid(nr, nc))
                        r.status = STAT_EDGE;
                    else
                    begin
                        ant_r = nr[COORD_W-1:0];
                        ant_c = nc[COORD_W-1:0];
                    end
                end
            end
            KIND_LOAD:
            begin
                rule_on[w.shade]   = (w.turn != TURN_OFF);
                rule_turn[w.shade] = (w.turn != TURN_OFF) ? w.turn : TURN_LEFT;
                rule_repl[w.shade] = w.new_shade;
            end
            KIND_WRITE:
            begin
                if (!on_grid(int'(w.row), int'(w.col)))
                    r.status = STAT_EDGE;
                else
                    shade_grid[int'(w.row) * GRID_SIDE + int'(w.col)] = w.shade;
            end
            KIND_PLACE:
            begin
                if (!on_grid(int'(w.row), int'(w.col)))
                    r.status = STAT_EDGE;
                else
                begin
                    ant_r = w.row;
                    ant_c = w.col;
                    ant_h = w.heading;
                end
            end
            KIND_READ:
            begin
                if (!on_grid(int'(w.row), int'(w.col)))
                    r.status = STAT_EDGE;
                else
                    r.rd = shade_grid[int'(w.row) * GRID_SIDE + int'(w.col)];
            end
            default:
            begin
            end
        endcase
        r.arow  = ant_r;
        r.acol  = ant_c;
        r.ahead = ant_h;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report(string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        n_err++;
    endtask

    task automatic check_field(string fname, int got, int want);
        if (got != want)
            report($sformatf("result %0d %s got %0d expected %0d", n_out, fname, got, want));
    endtask

    // result words are checked before the input word of the same edge is queued
    always @(posedge clk)
    begin : monitor
        out_word_t e;
        in_word_t  w;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (owed_results.size() == 0)
                    report($sformatf("result %0d arrived with nothing pending", n_out));
                else
                begin
                    e = owed_results.pop_front();
                    check_field("status", status, e.status);
                    check_field("ant_row_out", ant_row_out, e.arow);
                    check_field("ant_col_out", ant_col_out, e.acol);
                    check_field("ant_heading_out", ant_heading_out, e.ahead);
                    check_field("read_shade", read_shade, e.rd);
                end
                n_out++;
            end
            if (in_valid && !in_stall)
            begin
                w = {kind, row, col, shade, new_shade, turn, heading};
                e = apply_word(w);
                if (drv_chk)
                    e = drv_res;
                owed_results = {owed_results, e};
                n_in++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output side: random stalls, plus one long hold-off early on
    // ------------------------------------------------------------------
    initial
    begin : rx
        int  run;
        int  hold;
        int  roll;
        bit  level;
        bit  held;
        run   = 0;
        hold  = 0;
        level = 1'b0;
        held  = 1'b0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!held && n_in >= 40)
            begin
                hold = 80;
                held = 1'b1;
            end
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                hold--;
            end
            else
            begin
                if (run == 0)
                begin
                    roll = $urandom_range(0, 99);
                    if (roll < 65)
                    begin
                        level = 1'b0;
                        run   = $urandom_range(1, 8);
                    end
                    else if (roll < 93)
                    begin
                        level = 1'b1;
                        run   = $urandom_range(1, 3);
                    end
                    else
                    begin
                        level = 1'b1;
                        run   = $urandom_range(10, 40);
                    end
                end
                out_stall <= no_idle ? 1'b0 : level;
                run--;
            end
        end
    end

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (no_idle || roll < 60)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic in_word_t any_word();
        logic [31:0] bits;
        bits = $urandom;
        return bits[$bits(in_word_t)-1:0];
    endfunction

    // mostly inside the grid in use, sometimes anywhere
    function automatic logic [COORD_W-1:0] pick_coord(logic [DIM_W-1:0] dim);
        int v;
        if ($urandom_range(0, 99) < 85)
            v = $urandom_range(0, clamp_dim(dim) - 1);
        else
            v = $urandom_range(0, 255);
        return v[COORD_W-1:0];
    endfunction

    // entered and left just after a falling edge
    task automatic send_word(in_word_t w, logic chk, out_word_t res);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        kind      <= w.kind;
        row       <= w.row;
        col       <= w.col;
        shade     <= w.shade;
        new_shade <= w.new_shade;
        turn      <= w.turn;
        heading   <= w.heading;
        drv_chk   <= chk;
        drv_res   <= res;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    // setup and access cycle, then psel and penable drop before returning
    task automatic apb_write(logic [APB_AW-1:0] addr, logic [DIM_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= APB_DW'(val);
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (addr == ADDR_WIDTH)
            grid_w = val;
        else
            grid_h = val;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    task automatic drain();
        while (owed_results.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    // rule set first, then mostly steps with writes, reads, moves and noise
    task automatic run_phase(int n_items);
        in_word_t w;
        int       n_sh;
        int       roll;
        n_sh = $urandom_range(2, NUM_SHADES);
        for (int k = 0; k < n_sh; k++)
        begin
            w = any_word();
            w.kind      = KIND_LOAD;
            w.shade     = SHADE_W'(k);
            w.new_shade = SHADE_W'($urandom_range(0, n_sh - 1));
            w.turn      = TURN_W'($urandom_range(0, 2));
            send_word(w, PRED, NO_RES);
        end
        // leave the ant where it is half the time, possibly off a shrunken grid
        if ($urandom_range(0, 1) == 1)
        begin
            w = any_word();
            w.kind = KIND_PLACE;
            w.row  = pick_coord(grid_h);
            w.col  = pick_coord(grid_w);
            send_word(w, PRED, NO_RES);
        end
        for (int k = 0; k < n_items; k++)
        begin
            w = any_word();
            roll = $urandom_range(0, 99);
            if (roll < 58)
                w.kind = KIND_STEP;
            else if (roll < 68)
            begin
                w.kind = KIND_WRITE;
                w.row  = pick_coord(grid_h);
                w.col  = pick_coord(grid_w);
                if (roll < 65)
                    w.shade = SHADE_W'($urandom_range(0, n_sh - 1));
            end
            else if (roll < 78)
            begin
                w.kind = KIND_READ;
                w.row  = pick_coord(grid_h);
                w.col  = pick_coord(grid_w);
            end
            else if (roll < 84)
            begin
                w.kind = KIND_PLACE;
                w.row  = pick_coord(grid_h);
                w.col  = pick_coord(grid_w);
            end
            else if (roll < 91)
                w.kind = KIND_LOAD;
            send_word(w, PRED, NO_RES);
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin : main
        logic [DIM_W-1:0] ph_w [N_PHASES];
        logic [DIM_W-1:0] ph_h [N_PHASES];
        ph_w = '{9'd256, 9'd1, 9'd0, 9'd511, 9'd8, 9'd3, 9'd2, 9'd256, 9'd0, 9'd16};
        ph_h = '{9'd256, 9'd1, 9'd0, 9'd300, 9'd5, 9'd17, 9'd256, 9'd2, 9'd0, 9'd16};
        ph_w[8] = DIM_W'($urandom_range(1, 40));
        ph_h[8] = DIM_W'($urandom_range(1, 40));

        // directed words, starting from the reset state (256 x 256 grid)
        dir_tab = '{
            '{'{KIND_READ, 8'd0, 8'd0, 4'd0, 4'd0, TURN_LEFT, HEAD_N}, CHK,
              '{STAT_OK, 8'd0, 8'd0, HEAD_N, 4'd0}},
            '{'{KIND_READ, 8'd255, 8'd255, 4'd0, 4'd0, TURN_LEFT, HEAD_N}, CHK,
              '{STAT_OK, 8'd0, 8'd0, HEAD_N, 4'd0}},
            // step on a shade with no rule
            '{'{KIND_STEP, 8'd0, 8'd0, 4'd0, 4'd0, TURN_LEFT, HEAD_N}, CHK,
              '{STAT_NORULE, 8'd0, 8'd0, HEAD_N, 4'd0}},
            '{'{KIND_LOAD, 8'd0, 8'd0, 4'd0, 4'd1, TURN_RIGHT, HEAD_N}, CHK,
              '{STAT_OK, 8'd0, 8'd0, HEAD_N, 4'd0}},
            '{'{KIND_LOAD, 8'd0, 8'd0, 4'd1, 4'd0, TURN_LEFT, HEAD_N}, CHK,
              '{STAT_OK, 8'd0, 8'd0, HEAD_N, 4'd0}},
            '{'{KIND_LOAD, 8'd0, 8'd0, 4'd15, 4'd15, TURN_NONE, HEAD_N}, CHK,
              '{STAT_OK, 8'd0, 8'd0, HEAD_N, 4'd0}},
            '{'{KIND_STEP, 8'd0, 8'd0, 4'd0, 4'd0, TURN_LEFT, HEAD_N}, CHK,
              '{STAT_OK, 8'd0, 8'd1, HEAD_E, 4'd0}},
            '{'{KIND_STEP, 8'd0, 8'd0, 4'd0, 4'd0, TURN_LEFT, HEAD_N}, PRED, NO_RES},
            '{'{KIND_PLACE, 8'd0, 8'd0, 4'd0, 4'd0, TURN_LEFT, HEAD_N}, CHK,
              '{STAT_OK, 8'd0, 8'd0, HEAD_N, 4'd0}},
            // left turn wraps north to west, then the top-left corner blocks
            '{'{KIND_STEP, 8'd0, 8'd0, 4'd0, 4'd0, TURN_LEFT, HEAD_N}, CHK,
              '{STAT_EDGE, 8'd0, 8'd0, HEAD_WEST, 4'd0}},
            '{'{KIND_PLACE, 8'd255, 8'd255, 4'd0, 4'd0, TURN_LEFT, HEAD_WEST}, CHK,
              '{STAT_OK, 8'd255, 8'd255, HEAD_WEST, 4'd0}},
            '{'{KIND_STEP, 8'd0, 8'd0, 4'd0, 4'd0, TURN_LEFT, HEAD_N}, PRED, NO_RES},
            '{'{KIND_PLACE, 8'd255, 8'd255, 4'd0, 4'd0, TURN_LEFT, HEAD_S}, CHK,
              '{STAT_OK, 8'd255, 8'd255, HEAD_S, 4'd0}},
            // far corner, heading east off the grid
            '{'{KIND_STEP, 8'd0, 8'd0, 4'd0, 4'd0, TURN_LEFT, HEAD_N}, PRED, NO_RES},
            '{'{KIND_WRITE, 8'd170, 8'd85, 4'd15, 4'd0, TURN_LEFT, HEAD_N}, CHK,
              '{STAT_OK, 8'd255, 8'd255, HEAD_E, 4'd0}},
            '{'{KIND_READ, 8'd170, 8'd85, 4'd0, 4'd0, TURN_LEFT, HEAD_N}, CHK,
              '{STAT_OK, 8'd255, 8'd255, HEAD_E, 4'd15}},
            // turn code three drops the rule
            '{'{KIND_LOAD, 8'd0, 8'd0, 4'd15, 4'd0, TURN_OFF, HEAD_N}, CHK,
              '{STAT_OK, 8'd255, 8'd255, HEAD_E, 4'd0}},
            '{'{KIND_PLACE, 8'd170, 8'd85, 4'd0, 4'd0, TURN_LEFT, HEAD_E}, CHK,
              '{STAT_OK, 8'd170, 8'd85, HEAD_E, 4'd0}},
            '{'{KIND_STEP, 8'd0, 8'd0, 4'd0, 4'd0, TURN_LEFT, HEAD_N}, CHK,
              '{STAT_NORULE, 8'd170, 8'd85, HEAD_E, 4'd0}},
            // unused kinds do nothing
            '{'{KIND_SPARE0, 8'd1, 8'd2, 4'd3, 4'd4, TURN_RIGHT, HEAD_S}, CHK,
              '{STAT_OK, 8'd170, 8'd85, HEAD_E, 4'd0}},
            '{'{KIND_SPARE1, 8'd85, 8'd170, 4'd5, 4'd10, TURN_NONE, HEAD_E}, CHK,
              '{STAT_OK, 8'd170, 8'd85, HEAD_E, 4'd0}},
            '{'{KIND_SPARE2, 8'd255, 8'd255, 4'd15, 4'd15, TURN_OFF, HEAD_WEST}, CHK,
              '{STAT_OK, 8'd170, 8'd85, HEAD_E, 4'd0}},
            '{'{KIND_LOAD, 8'd0, 8'd0, 4'd10, 4'd5, TURN_NONE, HEAD_N}, PRED, NO_RES},
            '{'{KIND_WRITE, 8'd85, 8'd170, 4'd10, 4'd0, TURN_LEFT, HEAD_N}, PRED, NO_RES},
            '{'{KIND_READ, 8'd85, 8'd170, 4'd0, 4'd0, TURN_LEFT, HEAD_N}, PRED, NO_RES}
        };

        n_err     = 0;
        n_in      = 0;
        n_out     = 0;
        no_idle   = 1'b0;
        rst_n     = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        in_valid  = 1'b0;
        kind      = KIND_STEP;
        row       = '0;
        col       = '0;
        shade     = '0;
        new_shade = '0;
        turn      = TURN_LEFT;
        heading   = HEAD_N;
        drv_chk   = 1'b0;
        drv_res   = NO_RES;
        clear_model();

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        // the first word waits out the clearing pass on in_stall
        for (int i = 0; i < N_DIR; i++)
            send_word(dir_tab[i].w, dir_tab[i].chk, dir_tab[i].res);

        // random phases, each under its own grid size
        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            in_valid <= 1'b0;
            drain();
            apb_write(ADDR_WIDTH, ph_w[ph]);
            apb_write(ADDR_HEIGHT, ph_h[ph]);
            no_idle = (ph % 4 == 3);
            run_phase(95);
        end
        in_valid <= 1'b0;

        drain();
        repeat (20) @(posedge clk);
        if (n_err == 0)
            $display("multicolor_ant_grid_step regression: pass");
        else
            $display("multicolor_ant_grid_step regression: fail");
        $finish;
    end

    // watchdog
    initial
    begin
        #10ms;
        $display("[%0t] timeout", $realtime);
        $display("multicolor_ant_grid_step regression: fail");
        $finish;
    end

endmodule
`default_nettype wire

// File: files.f
hdl/mag_pkg.sv
hdl/mag_cell_ram.sv
hdl/mag_cfg.sv
hdl/mag_ctrl.sv
hdl/multicolor_ant_grid_step.sv
dv/testbench.sv
